[hdl/vector_easing_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// vector easing interpolator assertion macros
// shared property forms, sampled on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef VECTOR_EASING_INTERPOLATOR_DEFINES_SVH
`define VECTOR_EASING_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define VEI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vei: same-cycle check failed");

// next-cycle implication
`define VEI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vei: next-cycle check failed");

`endif

[hdl/vei_pkg.sv]
// ----------------------------------------------------------------------------
// vei_pkg
// shared types, constants and table builders of the vector easing interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package vei_pkg;

  localparam int COORD_WIDTH        = 32;
  localparam int PROGRESS_WIDTH     = 18;
  localparam int OP_WIDTH           = 3;
  localparam int MANT_BITS          = 30;
  localparam int TIME_FRAC_BITS_DEF = 14;
  localparam int EXP_TABLE_BITS_DEF = 8;
  localparam int EXP_TABLE_BITS_MAX = 12;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_IN_QUAD    = 3'd0,
    OP_OUT_QUAD   = 3'd1,
    OP_INOUT_QUAD = 3'd2,
    OP_LINEAR     = 3'd3,
    OP_IN_EXPO    = 3'd4,
    OP_OUT_EXPO   = 3'd5,
    OP_INOUT_EXPO = 3'd6
  } op_t;

  typedef struct packed {
    logic signed [PROGRESS_WIDTH-1:0] progress;
    logic        [OP_WIDTH-1:0]       operation;
    logic signed [COORD_WIDTH-1:0]    start_x;
    logic signed [COORD_WIDTH-1:0]    start_y;
    logic signed [COORD_WIDTH-1:0]    start_z;
    logic signed [COORD_WIDTH-1:0]    goal_x;
    logic signed [COORD_WIDTH-1:0]    goal_y;
    logic signed [COORD_WIDTH-1:0]    goal_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] eased_x;
    logic signed [COORD_WIDTH-1:0] eased_y;
    logic signed [COORD_WIDTH-1:0] eased_z;
  } out_item_t;

  // per-stage load strobes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } adv_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(idx / 2^etb) as q1.30, built from repeated square roots of two
  function automatic logic [63:0] exp_rom_entry(input int idx, input int etb);
    logic [63:0] roots [0:EXP_TABLE_BITS_MAX];
    logic [63:0] acc;
    acc      = 64'd1 << MANT_BITS;
    roots[0] = 64'd2 << MANT_BITS;
    for (int j = 1; j <= EXP_TABLE_BITS_MAX; j++) begin
      roots[j] = isqrt64(roots[j-1] << MANT_BITS);
    end
    for (int i = etb - 1; i >= 0; i--) begin
      if (idx[i]) begin
        acc = (acc * roots[etb-i] + (64'd1 << (MANT_BITS - 1))) >> MANT_BITS;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

[hdl/vector_easing_interpolator.sv]
// ----------------------------------------------------------------------------
// vector_easing_interpolator
// eases a start 3-vector towards a goal 3-vector by a quad, linear or expo
// weight of clamped progress, five register stages, when not stalled one transfer per cycle
// ----------------------------------------------------------------------------
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------
//   item     | item_valid / item_ready     | in_item_t  (progress, op, vectors)
//   result   | result_valid / result_ready | out_item_t (eased x, y, z)
//
// one item is taken per cycle while item_ready is high; results leave in item order
// the five pipeline stages each hold a valid bit that travels with the data
// a stage loads whenever it is empty or the stage after it moves, so bubbles
// close up while the result side is stalled and item_ready falls only when
// all five stages are full and the result is not taken
// rst (synchronous) clears the valid bits only; payload registers are not reset
//
`default_nettype none

`include "vector_easing_interpolator_defines.svh"

module vector_easing_interpolator
  import vei_pkg::*;
#(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF,
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  localparam int NSTAGE = 5;

  // stage occupancy and flow control
  logic [NSTAGE:1]   v;
  logic [NSTAGE:1]   v_next;
  logic [NSTAGE+1:1] free;
  adv_t              adv;

  always_comb begin
    free[NSTAGE+1] = result_ready;
    for (int k = NSTAGE; k >= 1; k--) begin
      free[k] = !v[k] || free[k+1];
    end
  end

  // a stage loads when the one before it holds an item and it can move on
  assign adv.s1 = item_valid && free[1];
  assign adv.s2 = v[1] && free[2];
  assign adv.s3 = v[2] && free[3];
  assign adv.s4 = v[3] && free[4];
  assign adv.s5 = v[4] && free[5];

  always_comb begin
    v_next[1] = free[1] ? item_valid : v[1];
    for (int k = 2; k <= NSTAGE; k++) begin
      v_next[k] = free[k] ? v[k-1] : v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  assign item_ready   = free[1];
  assign result_valid = v[NSTAGE];

  // weight path: clamp, quad product or expo split, table and final pick
  logic [TIME_FRAC_BITS:0] weight;

  vei_weight #(
    .TIME_FRAC_BITS (TIME_FRAC_BITS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_weight (
    .clk       (clk),
    .adv       (adv),
    .progress  (item.progress),
    .operation (item.operation),
    .weight    (weight)
  );

  // three coordinate lanes share the weight from stage three
  logic signed [COORD_WIDTH-1:0] eased_x;
  logic signed [COORD_WIDTH-1:0] eased_y;
  logic signed [COORD_WIDTH-1:0] eased_z;

  vei_lerp #(
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_lerp_x (
    .clk    (clk),
    .adv    (adv),
    .start  (item.start_x),
    .goal   (item.goal_x),
    .weight (weight),
    .eased  (eased_x)
  );

  vei_lerp #(
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_lerp_y (
    .clk    (clk),
    .adv    (adv),
    .start  (item.start_y),
    .goal   (item.goal_y),
    .weight (weight),
    .eased  (eased_y)
  );

  vei_lerp #(
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_lerp_z (
    .clk    (clk),
    .adv    (adv),
    .start  (item.start_z),
    .goal   (item.goal_z),
    .weight (weight),
    .eased  (eased_z)
  );

  assign result = {eased_x, eased_y, eased_z};

  // full pipeline with the result held back must stop the item side
  `VEI_ASSERT_IMPL(a_full_stall, (&v) && !result_ready, !item_ready)
  // an item in with nothing out grows occupancy by one
  `VEI_ASSERT_NEXT(a_fill_count, (item_valid && item_ready) && !(result_valid && result_ready), $countones(v) == $past($countones(v)) + 1)
  // a result out with nothing in shrinks occupancy by one
  `VEI_ASSERT_NEXT(a_drain_count, !(item_valid && item_ready) && (result_valid && result_ready), $countones(v) + 1 == $past($countones(v)))

endmodule

`default_nettype wire

[hdl/vei_weight.sv]
// ----------------------------------------------------------------------------
// vei_weight
// clamps progress and forms the easing weight over three register stages
// ----------------------------------------------------------------------------
`default_nettype none

module vei_weight
  import vei_pkg::*;
#(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF,
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  logic                             clk,
  input  adv_t                             adv,
  input  logic signed [PROGRESS_WIDTH-1:0] progress,
  input  logic        [OP_WIDTH-1:0]       operation,
  output logic        [TIME_FRAC_BITS:0]   weight
);

  localparam int TW      = TIME_FRAC_BITS + 1;
  localparam int MW      = TW + 1;
  localparam int PW      = 2 * MW;
  localparam int AW      = TW + 4;
  localparam int NW      = AW - TIME_FRAC_BITS;
  localparam int SW      = 6;
  localparam int ONE_INT = 1 << TIME_FRAC_BITS;
  localparam int ROM_N   = 1 << EXP_TABLE_BITS;
  localparam logic [TW-1:0] ONE = TW'(1) << TIME_FRAC_BITS;

  typedef enum logic [2:0] {
    K_QROUND, K_QLOW, K_QHIGH, K_LIN, K_EXP, K_ONE_MINUS, K_ZERO, K_FULL
  } kind_t;

  // stage 1: clamp
  logic signed [31:0] p_ext;
  logic [TW-1:0]      t_clamp;
  logic [TW-1:0]      t1;
  op_t                op1;

  assign p_ext = 32'(progress);

  always_comb begin
    if (p_ext < 0) begin
      t_clamp = '0;
    end else if (p_ext > ONE_INT) begin
      t_clamp = ONE;
    end else begin
      t_clamp = p_ext[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      t1  <= t_clamp;
      op1 <= op_t'(operation);
    end
  end

  // stage 2: quad product, expo exponent split
  logic [MW-1:0]             u;
  logic [MW-1:0]             v;
  logic [MW-1:0]             two_one;
  logic [MW-1:0]             mul_a;
  logic [MW-1:0]             mul_b;
  logic                      low;
  logic                      extra;
  logic [TW-1:0]             arg;
  logic [AW-1:0]             a10;
  logic [AW-1:0]             a_up;
  logic [NW-1:0]             nneg;
  logic [TIME_FRAC_BITS-1:0] frac;
  logic [EXP_TABLE_BITS-1:0] idx;
  kind_t                     kind;

  logic [PW-1:0]             prod2;
  logic [EXP_TABLE_BITS-1:0] idx2;
  logic [SW-1:0]             shamt2;
  logic [TW-1:0]             t2;
  kind_t                     kind2;

  assign u       = {t1, 1'b0};
  assign v       = u - MW'(ONE);
  assign two_one = MW'(2) << TIME_FRAC_BITS;
  assign low     = u < MW'(ONE);

  always_comb begin
    mul_a = MW'(t1);
    mul_b = MW'(t1);
    arg   = t1;
    extra = 1'b0;
    kind  = K_LIN;
    case (op1)
      OP_IN_QUAD: begin
        kind = K_QROUND;
      end
      OP_OUT_QUAD: begin
        mul_b = two_one - MW'(t1);
        kind  = K_QROUND;
      end
      OP_INOUT_QUAD: begin
        if (low) begin
          mul_a = u;
          mul_b = u;
          kind  = K_QLOW;
        end else begin
          mul_a = v;
          mul_b = two_one - v;
          kind  = K_QHIGH;
        end
      end
      OP_IN_EXPO: begin
        arg  = ONE - t1;
        kind = (t1 == '0) ? K_ZERO : K_EXP;
      end
      OP_OUT_EXPO: begin
        arg  = t1;
        kind = (t1 == ONE) ? K_FULL : K_ONE_MINUS;
      end
      OP_INOUT_EXPO: begin
        extra = 1'b1;
        if (low) begin
          arg  = TW'(MW'(ONE) - u);
          kind = K_EXP;
        end else begin
          arg  = TW'(v);
          kind = K_ONE_MINUS;
        end
        if (t1 == '0) begin
          kind = K_ZERO;
        end else if (t1 == ONE) begin
          kind = K_FULL;
        end
      end
      default: begin
        kind = K_LIN;
      end
    endcase
  end

  assign a10  = (AW'(arg) << 3) + (AW'(arg) << 1);
  assign a_up = a10 + AW'(ONE - TW'(1));
  assign nneg = a_up[AW-1:TIME_FRAC_BITS];
  assign frac = TIME_FRAC_BITS'(0) - a10[TIME_FRAC_BITS-1:0];

  generate
    if (TIME_FRAC_BITS >= EXP_TABLE_BITS) begin : g_idx_trunc
      assign idx = frac[TIME_FRAC_BITS-1 -: EXP_TABLE_BITS];
    end else begin : g_idx_pad
      assign idx = {frac, {(EXP_TABLE_BITS - TIME_FRAC_BITS){1'b0}}};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      prod2  <= mul_a * mul_b;
      idx2   <= idx;
      shamt2 <= SW'(MANT_BITS - TIME_FRAC_BITS) + SW'(extra) + SW'(nneg);
      t2     <= t1;
      kind2  <= kind;
    end
  end

  // stage 3: table lookup, rounding shift, final selection
  logic [MANT_BITS:0] rom [ROM_N];

  generate
    for (genvar i = 0; i < ROM_N; i++) begin : g_rom
      localparam logic [63:0] ENTRY = exp_rom_entry(i, EXP_TABLE_BITS);
      assign rom[i] = ENTRY[MANT_BITS:0];
    end
  endgenerate

  logic [63:0]   pow_sum;
  logic [63:0]   pow_sh;
  logic [TW-1:0] pow;
  logic [PW:0]   q_round;
  logic [PW:0]   q_low;
  logic [PW:0]   q_high;
  logic [TW-1:0] w_sel;

  assign pow_sum = 64'(rom[idx2]) + (64'd1 << (shamt2 - SW'(1)));
  assign pow_sh  = pow_sum >> shamt2;
  assign pow     = (shamt2 >= SW'(63)) ? '0 : pow_sh[TW-1:0];

  assign q_round = {1'b0, prod2} + ((PW + 1)'(1) << (TIME_FRAC_BITS - 1));
  assign q_low   = {1'b0, prod2} + (PW + 1)'(ONE);
  assign q_high  = {1'b0, prod2} + ((PW + 1)'(1) << (2 * TIME_FRAC_BITS)) + (PW + 1)'(ONE);

  always_comb begin
    case (kind2)
      K_QROUND:    w_sel = q_round[TIME_FRAC_BITS +: TW];
      K_QLOW:      w_sel = q_low[TIME_FRAC_BITS + 1 +: TW];
      K_QHIGH:     w_sel = q_high[TIME_FRAC_BITS + 1 +: TW];
      K_EXP:       w_sel = pow;
      K_ONE_MINUS: w_sel = ONE - pow;
      K_ZERO:      w_sel = '0;
      K_FULL:      w_sel = ONE;
      default:     w_sel = t2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      weight <= w_sel;
    end
  end

endmodule

`default_nettype wire

[hdl/vei_lerp.sv]
// ----------------------------------------------------------------------------
// vei_lerp
// one coordinate lane: difference, magnitude times weight, round, add, saturate
// ----------------------------------------------------------------------------
`default_nettype none

module vei_lerp
  import vei_pkg::*;
#(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  adv_t                          adv,
  input  logic signed [COORD_WIDTH-1:0] start,
  input  logic signed [COORD_WIDTH-1:0] goal,
  input  logic        [TIME_FRAC_BITS:0] weight,
  output logic signed [COORD_WIDTH-1:0] eased
);

  localparam int CW = COORD_WIDTH;
  localparam int TW = TIME_FRAC_BITS + 1;
  localparam int PW = CW + 1 + TW;
  localparam logic signed [CW+2:0] MAXV = {{4{1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [CW+2:0] MINV = {{4{1'b1}}, {(CW - 1){1'b0}}};

  logic signed [CW-1:0] s1, s2, s3, s4;
  logic signed [CW-1:0] g1;
  logic signed [CW:0]   d2;
  logic        [CW:0]   mag3;
  logic                 neg3, neg4;
  logic        [PW-1:0] prod4;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1 <= start;
      g1 <= goal;
    end
    if (adv.s2) begin
      d2 <= (CW + 1)'(g1) - (CW + 1)'(s1);
      s2 <= s1;
    end
    if (adv.s3) begin
      neg3 <= d2[CW];
      mag3 <= d2[CW] ? (CW + 1)'(-d2) : (CW + 1)'(d2);
      s3   <= s2;
    end
    if (adv.s4) begin
      prod4 <= PW'(mag3) * PW'(weight);
      neg4  <= neg3;
      s4    <= s3;
    end
  end

  // round half away from zero on the magnitude, then apply the sign
  logic        [PW:0]   r_sum;
  logic        [CW:0]   r;
  logic signed [CW+2:0] r_ext;
  logic signed [CW+2:0] sum;

  assign r_sum = {1'b0, prod4} + ((PW + 1)'(1) << (TIME_FRAC_BITS - 1));
  assign r     = r_sum[TIME_FRAC_BITS +: CW + 1];
  assign r_ext = $signed({2'b00, r});
  assign sum   = (CW + 3)'(s4) + (neg4 ? -r_ext : r_ext);

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      if (sum > MAXV) begin
        eased <= MAXV[CW-1:0];
      end else if (sum < MINV) begin
        eased <= MINV[CW-1:0];
      end else begin
        eased <= sum[CW-1:0];
      end
    end
  end

endmodule

`default_nettype wire
